/* rtl/u16u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; imported by every module of the block.
package u16u8_pkg;

   localparam logic [15:0] SURR_MASK  = 16'hFC00;
   localparam logic [15:0] HIGH_SURR  = 16'hD800;
   localparam logic [15:0] LOW_SURR   = 16'hDC00;
   localparam logic [15:0] ASCII_MASK = 16'hFF80;
   localparam logic [15:0] TWO_MASK   = 16'hF800;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [2:0]  FLUSH_CNT  = 3'd3;

   // Length class of the main part of a job.
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_ONE   = 3'd1,
      KIND_TWO   = 3'd2,
      KIND_THREE = 3'd3,
      KIND_FOUR  = 3'd4
   } kind_type;

   // One queued job: optional flush of a held surrogate, then the main unit.
   // For KIND_FOUR, held_bits carries the high surrogate and unit the low one.
   typedef struct packed {
      logic        flush;
      logic [9:0]  held_bits;
      kind_type    kind;
      logic [15:0] unit;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* rtl/utf16_to_utf8_encoder.sv */
// UTF-16 to UTF-8 encoder. With the job queue empty, the first byte of a request passes
// through the job queue register and then the output register before it is on rsp_*.
// Output: one byte per cycle unless rsp_* is back-pressured; a BMP unit makes 1 to 3
// bytes, a surrogate pair 4, a unit that flushes an unpaired surrogate up to 6, set by the byte serializer.
// Requests enter every cycle while the job queue has room.
// Reset (synchronous, active high) clears the held surrogate, queue and output register.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
module utf16_to_utf8_encoder #(
   parameter int QUEUE_DEPTH = 2   // jobs between classifier and serializer, >= 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // last_of_run
);
   import u16u8_pkg::*;

   q_status_type q_status;
   job_type      push_job, head_job;
   logic         q_push, q_pop;

   // Classifier: holds high surrogates, emits one job per request that makes bytes.
   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   // Decouples request side from response backpressure.
   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Serializer: one byte per cycle, unless the receiver back-pressures, into a registered output stage.
   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // No job is pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // A job is retired only when one is present.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job popped from empty queue");

   // Retiring a job always puts its last byte into the output register.
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_tvalid && rsp_tlast))
      else $error("job retired without last byte");

   // Output stage comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

/* rtl/u16u8_front.sv */
// Front end: accepts code units, tracks the held high surrogate, classifies.
// Depends on u16u8_pkg; pushes jobs into u16u8_queue.
module u16u8_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,
   input  u16u8_pkg::q_status_type q_status,
   output logic                   q_push,
   output u16u8_pkg::job_type     q_job
);
   import u16u8_pkg::*;

   logic       pending_ff, pending_in;
   logic [9:0] held_ff, held_in;
   logic       accept;
   logic       is_high, is_low;
   job_type    job;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_high    = (req_tdata & SURR_MASK) == HIGH_SURR;
   assign is_low     = (req_tdata & SURR_MASK) == LOW_SURR;

   always_comb begin
      job.flush     = pending_ff;
      job.held_bits = held_ff;
      job.unit      = req_tdata;
      pending_in    = 1'b0;
      held_in       = held_ff;
      if (pending_ff && is_low) begin
         job.flush = 1'b0;
         job.kind  = KIND_FOUR;
      end else if ((req_tdata & ASCII_MASK) == 16'h0000) begin
         job.kind = KIND_ONE;   // includes the terminating zero
      end else if ((req_tdata & TWO_MASK) == 16'h0000) begin
         job.kind = KIND_TWO;
      end else if (is_high) begin
         job.kind   = KIND_NONE;
         pending_in = 1'b1;
         held_in    = req_tdata[9:0];
      end else begin
         job.kind = KIND_THREE;
      end
   end

   assign q_job  = job;
   assign q_push = accept && (job.flush || job.kind != KIND_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         held_ff    <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         held_ff    <= held_in;
      end
   end

endmodule

/* rtl/u16u8_queue.sv */
// Short job queue between front and back end.
// Depends on u16u8_pkg for the job and status types.
module u16u8_queue #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  u16u8_pkg::job_type      push_job,
   input  logic                    pop,
   output u16u8_pkg::job_type      head_job,
   output u16u8_pkg::q_status_type status
);
   import u16u8_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entries_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign head_job     = entries_ff[rd_ptr_ff];
   assign status.full  = count_ff == CW'(DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/u16u8_back.sv */
// Back end: walks the head job byte by byte into the output register.
// Depends on u16u8_pkg; pops u16u8_queue after the last byte of a job.
module u16u8_back (
   input  logic                    clock,
   input  logic                    reset,
   input  u16u8_pkg::job_type      head_job,
   input  u16u8_pkg::q_status_type q_status,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);
   import u16u8_pkg::*;

   logic [2:0]  idx_ff;
   logic        valid_ff;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic [2:0]  flush_n, main_n, total_n, main_idx3;
   logic [1:0]  main_idx;
   logic [20:0] cp;
   logic [7:0]  flush_byte, main_byte, byte_sel;
   logic        is_last, advance;

   assign flush_n   = head_job.flush ? FLUSH_CNT : 3'd0;
   assign total_n   = flush_n + main_n;
   assign main_idx3 = idx_ff - flush_n;
   assign main_idx  = main_idx3[1:0];
   assign cp        = SUPP_BASE + {1'b0, head_job.held_bits, head_job.unit[9:0]};

   always_comb begin
      case (head_job.kind)
         KIND_ONE:   main_n = 3'd1;
         KIND_TWO:   main_n = 3'd2;
         KIND_THREE: main_n = 3'd3;
         KIND_FOUR:  main_n = 3'd4;
         default:    main_n = 3'd0;
      endcase
   end

   // Held surrogate without a partner goes out as ED A0..AF 80..BF.
   always_comb begin
      case (idx_ff[1:0])
         2'd0:    flush_byte = 8'hED;
         2'd1:    flush_byte = {4'hA, head_job.held_bits[9:6]};
         default: flush_byte = {2'b10, head_job.held_bits[5:0]};
      endcase
   end

   always_comb begin
      main_byte = head_job.unit[7:0];
      case (head_job.kind)
         KIND_TWO: begin
            main_byte = (main_idx == 2'd0) ? {3'b110, head_job.unit[10:6]}
                                           : {2'b10, head_job.unit[5:0]};
         end
         KIND_THREE: begin
            case (main_idx)
               2'd0:    main_byte = {4'hE, head_job.unit[15:12]};
               2'd1:    main_byte = {2'b10, head_job.unit[11:6]};
               default: main_byte = {2'b10, head_job.unit[5:0]};
            endcase
         end
         KIND_FOUR: begin
            case (main_idx)
               2'd0:    main_byte = {5'b11110, cp[20:18]};
               2'd1:    main_byte = {2'b10, cp[17:12]};
               2'd2:    main_byte = {2'b10, cp[11:6]};
               default: main_byte = {2'b10, cp[5:0]};
            endcase
         end
         default: main_byte = head_job.unit[7:0];
      endcase
   end

   assign byte_sel = (idx_ff < flush_n) ? flush_byte : main_byte;
   assign is_last  = idx_ff == total_n - 3'd1;
   assign advance  = !q_status.empty && (!valid_ff || rsp_tready);
   assign q_pop    = advance && is_last;

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= byte_sel;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (advance) begin
            valid_ff <= 1'b1;
            idx_ff   <= is_last ? 3'd0 : idx_ff + 3'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for utf16_to_utf8_encoder: UTF-16 code units go in, and the
// UTF-8 byte stream is checked against an internal encoder. Needs only the block's RTL
// and its package.
`timescale 1ns / 100ps

// Tracks the held high surrogate and keeps the UTF-8 bytes still owed by the block.
class utf8_scoreboard;
   localparam logic [15:0] SURR_MASK  = 16'hFC00;
   localparam logic [15:0] HIGH_SURR  = 16'hD800;
   localparam logic [15:0] LOW_SURR   = 16'hDC00;
   localparam logic [15:0] ASCII_MASK = 16'hFF80;
   localparam logic [15:0] TWO_MASK   = 16'hF800;

   logic [8:0]  owed_bytes[$];   // {last_of_run, out_byte}
   bit          high_held;
   logic [9:0]  held_bits;
   int unsigned errors;

   function new();
      high_held = 1'b0;
      held_bits = '0;
      errors    = 0;
   endfunction

   function void push_byte(logic [7:0] b);
      owed_bytes.push_back({1'b0, b});
   endfunction

   function void push_three(logic [15:0] u);
      push_byte({4'hE, u[15:12]});
      push_byte({2'b10, u[11:6]});
      push_byte({2'b10, u[5:0]});
   endfunction

   // Works out the bytes one accepted request causes and queues them.
   function void note_request(logic [15:0] unit);
      int unsigned start_len;
      logic [20:0] point;
      start_len = owed_bytes.size();
      if (high_held && (unit & SURR_MASK) == LOW_SURR) begin
         // surrogate pair -> four-byte sequence
         point = 21'h10000 + {1'b0, held_bits, unit[9:0]};
         push_byte({5'b11110, point[20:18]});
         push_byte({2'b10, point[17:12]});
         push_byte({2'b10, point[11:6]});
         push_byte({2'b10, point[5:0]});
         high_held = 1'b0;
         held_bits = '0;
      end else begin
         if (high_held) begin
            // unpaired high surrogate goes out as three bytes first
            push_three(HIGH_SURR | {6'd0, held_bits});
            high_held = 1'b0;
            held_bits = '0;
         end
         if (unit == 16'h0000)
            push_byte(8'h00);
         else if ((unit & ASCII_MASK) == 16'h0000)
            push_byte(unit[7:0]);
         else if ((unit & TWO_MASK) == 16'h0000) begin
            push_byte({3'b110, unit[10:6]});
            push_byte({2'b10, unit[5:0]});
         end else if ((unit & SURR_MASK) == HIGH_SURR) begin
            high_held = 1'b1;
            held_bits = unit[9:0];
         end else
            push_three(unit);
      end
      if (owed_bytes.size() > start_len)
         owed_bytes[owed_bytes.size() - 1][8] = 1'b1;
   endfunction

   function void check_byte(logic [7:0] data, logic last);
      logic [8:0] owed;
      if (owed_bytes.size() == 0) begin
         $error("unexpected byte %h (last %b)", data, last);
         errors++;
         return;
      end
      owed = owed_bytes.pop_front();
      if (data !== owed[7:0]) begin
         $error("out_byte: expected %h, actual %h", owed[7:0], data);
         errors++;
      end
      if (last !== owed[8]) begin
         $error("last_of_run: expected %b, actual %b", owed[8], last);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int          RANDOM_ITEMS = 320;
   localparam int unsigned CYCLE_LIMIT  = 400000;  // far above the slowest legal run
   localparam int          DRAIN_CYCLES = 20;      // a few times the 6-byte worst case

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   utf8_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   bit             steady = 1'b0;   // when set, neither side idles

   utf16_to_utf8_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Receiver: back-pressure about 27% of cycles, none during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 27);
   end

   // Output monitor: every accepted byte goes against the oldest owed byte.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_byte(rsp_tdata, rsp_tlast);
   end

   // Drives one code unit; random idle cycles go ahead of it.
   task automatic send_unit(input logic [15:0] unit);
      while (!steady && $urandom_range(0, 99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(unit);
   endtask

   task automatic wait_for_drain();
      while (sb.owed_bytes.size() != 0)
         @(posedge clock);
   endtask

   // Non-surrogate BMP unit that needs three bytes.
   function automatic logic [15:0] three_byte_unit();
      logic [15:0] u;
      u = 16'($urandom_range(16'h0800, 16'hFFFF));
      while (u[15:11] == 5'b11011)
         u = 16'($urandom_range(16'h0800, 16'hFFFF));
      return u;
   endfunction

   initial begin
      logic [15:0] directed_units[$];
      int          pick;
      int          sent;
      directed_units = '{
         16'h0041, 16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
         16'hD7FF, 16'hE000,
         16'hDC00, 16'hDFFF,             // lone low surrogates
         16'hD800, 16'hDC00,             // lowest pair
         16'hDBFF, 16'hDFFF,             // highest pair
         16'hD83D, 16'hDBFF, 16'h0041,   // high after high, then flush before ASCII
         16'hDA55, 16'h0000,             // zero flushes a held surrogate
         16'hD801, 16'h07FF,             // flush then two bytes
         16'hDBFE, 16'hFFFF,             // flush then three: six bytes
         16'h0000                        // plain terminator
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_units[i])
         send_unit(directed_units[i]);

      // Hold off the sender until the block has delivered every owed byte.
      req_tvalid <= 1'b0;
      wait_for_drain();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = (sent >= 120 && sent < 200);
         pick = $urandom_range(0, 99);
         if (pick < 20)
            send_unit(16'($urandom_range(1, 16'h007F)));
         else if (pick < 35)
            send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
         else if (pick < 55)
            send_unit(three_byte_unit());
         else if (pick < 78) begin
            // well-formed pair with random content
            send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            sent++;
         end else if (pick < 86)
            send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));   // may go unpaired
         else if (pick < 91)
            send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));   // low surrogate, lone unless a high is held
         else if (pick < 94)
            send_unit(16'h0000);
         else
            send_unit(16'($urandom_range(0, 16'hFFFF)));
         sent++;
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.owed_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", sb.owed_bytes.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
